>>> hw/rtl/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types, codes and helpers for the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

  // Matrix geometry
  localparam int MAX_DIM = 8;
  localparam int DIM_W   = $clog2(MAX_DIM);      // row / column / inner index
  localparam int CNT_W   = DIM_W + 1;            // dimension register, 1..MAX_DIM
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = 2 * DIM_W;

  // Arithmetic widths
  localparam int ELEM_W = 16;                    // Q8.8
  localparam int PROD_W = 2 * ELEM_W;            // Q16.16, exact
  localparam int ACC_W  = PROD_W + DIM_W + 1;    // exact sum of MAX_DIM products
  localparam int RES_W  = 32;                    // saturated Q16.16

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COLS = 2'd3;

  // Function codes of an input word
  localparam logic [1:0] FUNC_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE    = 2'd2;

  // Input word
  typedef struct packed {
    logic [1:0]              func;
    logic [DIM_W-1:0]        elem_row;
    logic [DIM_W-1:0]        elem_col;
    logic signed [ELEM_W-1:0] elem_value;
  } in_t;

  // Result word
  typedef struct packed {
    logic [DIM_W-1:0]        out_row;
    logic [DIM_W-1:0]        out_col;
    logic signed [RES_W-1:0] out_value;
    logic                    dim_error;
    logic                    last;
  } out_t;

  // Tag that travels with each pair of store reads
  typedef struct packed {
    logic vld;
    logic first;   // first inner step of an element
    logic lastk;   // final inner step of an element
  } tag_t;

  // Result load request from the sequencer
  typedef struct packed {
    logic             load;
    logic             err;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic             last;
  } emit_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_ERR
  } state_e;

  // Effective dimension: zero acts as one, anything above MAX_DIM as MAX_DIM
  function automatic logic [CNT_W-1:0] eff_dim(input logic [CFG_DATA_W-1:0] reg_val);
    logic [CNT_W-1:0] res;
    if (reg_val == '0) begin
      res = CNT_W'(1);
    end else if (reg_val > CFG_DATA_W'(MAX_DIM)) begin
      res = CNT_W'(MAX_DIM);
    end else begin
      res = CNT_W'(reg_val);
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/mme_ram.sv
// ----------------------------------------------------------------------------
// mme_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/mme_mac.sv
// ----------------------------------------------------------------------------
// mme_mac
// Multiply-accumulate datapath: store read data -> product -> exact sum,
// then saturation to signed 32 bits.
// ----------------------------------------------------------------------------
module mme_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mme_pkg::tag_t                    tag_i,      // tag of reads issued this cycle
  input  logic [mme_pkg::ELEM_W-1:0]       left_i,     // read data, in the cycle after its tag
  input  logic [mme_pkg::ELEM_W-1:0]       right_i,
  input  logic                             emit_i,     // sum consumed
  output logic                             done_o,
  output logic signed [mme_pkg::RES_W-1:0] value_o
);

  mme_pkg::tag_t                    s1_q, s2_q;
  logic signed [mme_pkg::PROD_W-1:0] prod_q;
  logic signed [mme_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic signed [mme_pkg::ACC_W-1:0]  prod_ext;
  logic                              done_q;

  // Tags follow the read and multiply stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= tag_i;
      s2_q <= s1_q;
    end
  end

  // Product stage
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(left_i) * $signed(right_i);
  end

  // Accumulate stage
  assign prod_ext = mme_pkg::ACC_W'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (s2_q.vld) begin
      acc_d = s2_q.first ? prod_ext : acc_q + prod_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Sum complete after the final inner step, until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else if (s2_q.vld && s2_q.lastk) begin
      done_q <= 1'b1;
    end else if (emit_i) begin
      done_q <= 1'b0;
    end
  end

  // Saturate: in range when all bits above the result sign agree
  always_comb begin
    if (acc_q[mme_pkg::ACC_W-1:mme_pkg::RES_W-1] == '0 ||
        acc_q[mme_pkg::ACC_W-1:mme_pkg::RES_W-1] == '1) begin
      value_o = acc_q[mme_pkg::RES_W-1:0];
    end else if (acc_q[mme_pkg::ACC_W-1]) begin
      value_o = {1'b1, {(mme_pkg::RES_W-1){1'b0}}};
    end else begin
      value_o = {1'b0, {(mme_pkg::RES_W-1){1'b1}}};
    end
  end

  assign done_o = done_q;

endmodule

>>> hw/rtl/mme_ctrl.sv
// ----------------------------------------------------------------------------
// mme_ctrl
// Sequencer: accepts input words, writes loads into the stores, walks
// row / column / inner indices for a compute and requests result loads.
// ----------------------------------------------------------------------------
module mme_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  mme_pkg::in_t                 in_word_i,
  output logic                         in_stall_o,
  input  logic [mme_pkg::CNT_W-1:0]    n_rows_i,
  input  logic [mme_pkg::CNT_W-1:0]    n_inner_i,
  input  logic [mme_pkg::CNT_W-1:0]    n_inner_r_i,
  input  logic [mme_pkg::CNT_W-1:0]    n_cols_i,
  input  logic                         out_free_i,
  input  logic                         acc_done_i,
  output logic                         left_we_o,
  output logic                         right_we_o,
  output logic [mme_pkg::ADDR_W-1:0]   waddr_o,
  output logic [mme_pkg::ELEM_W-1:0]   wdata_o,
  output logic [mme_pkg::ADDR_W-1:0]   left_raddr_o,
  output logic [mme_pkg::ADDR_W-1:0]   right_raddr_o,
  output mme_pkg::tag_t                tag_o,
  output mme_pkg::emit_t               emit_o
);

  mme_pkg::state_e              state_q, state_d;
  logic [mme_pkg::DIM_W-1:0]    row_q, col_q, k_q;
  logic                         accept, is_compute, k_last, row_last, col_last;
  logic                         emit_elem;

  assign accept     = in_valid_i && (state_q == mme_pkg::ST_IDLE);
  assign is_compute = (in_word_i.func == mme_pkg::FUNC_COMPUTE);
  assign k_last     = (mme_pkg::CNT_W'(k_q) + mme_pkg::CNT_W'(1)) == n_inner_i;
  assign row_last   = (mme_pkg::CNT_W'(row_q) + mme_pkg::CNT_W'(1)) == n_rows_i;
  assign col_last   = (mme_pkg::CNT_W'(col_q) + mme_pkg::CNT_W'(1)) == n_cols_i;
  assign emit_elem  = (state_q == mme_pkg::ST_DRAIN) && acc_done_i && out_free_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mme_pkg::ST_IDLE: begin
        if (accept && is_compute) begin
          state_d = (n_inner_i != n_inner_r_i) ? mme_pkg::ST_ERR : mme_pkg::ST_ISSUE;
        end
      end
      mme_pkg::ST_ISSUE: begin
        if (k_last) begin
          state_d = mme_pkg::ST_DRAIN;
        end
      end
      mme_pkg::ST_DRAIN: begin
        if (emit_elem) begin
          state_d = (row_last && col_last) ? mme_pkg::ST_IDLE : mme_pkg::ST_ISSUE;
        end
      end
      mme_pkg::ST_ERR: begin
        if (out_free_i) begin
          state_d = mme_pkg::ST_IDLE;
        end
      end
      default: state_d = mme_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mme_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Outputs
  always_comb begin
    in_stall_o  = 1'b1;
    left_we_o   = 1'b0;
    right_we_o  = 1'b0;
    tag_o       = '0;
    emit_o      = '0;
    unique case (state_q)
      mme_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        left_we_o  = accept && (in_word_i.func == mme_pkg::FUNC_LOAD_LEFT);
        right_we_o = accept && (in_word_i.func == mme_pkg::FUNC_LOAD_RIGHT);
      end
      mme_pkg::ST_ISSUE: begin
        tag_o.vld   = 1'b1;
        tag_o.first = (k_q == '0);
        tag_o.lastk = k_last;
      end
      mme_pkg::ST_DRAIN: begin
        emit_o.load = emit_elem;
        emit_o.row  = row_q;
        emit_o.col  = col_q;
        emit_o.last = row_last && col_last;
      end
      mme_pkg::ST_ERR: begin
        emit_o.load = out_free_i;
        emit_o.err  = 1'b1;
        emit_o.last = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Store addresses: row-major, row * MAX_DIM + column
  assign waddr_o       = {in_word_i.elem_row, in_word_i.elem_col};
  assign wdata_o       = in_word_i.elem_value;
  assign left_raddr_o  = {row_q, k_q};
  assign right_raddr_o = {k_q, col_q};

  // Index counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      k_q   <= '0;
    end else begin
      if (accept && is_compute) begin
        row_q <= '0;
        col_q <= '0;
        k_q   <= '0;
      end
      if (state_q == mme_pkg::ST_ISSUE) begin
        k_q <= k_last ? '0 : k_q + 1'b1;
      end
      if (emit_elem) begin
        if (col_last) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/matrix_multiply_engine.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Loads left and right Q8.8 matrices into two stores and emits their product
// in row-major order as saturated Q16.16 words.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+--------------------------
//  in      | input     | in_valid_i / in_stall_o  | mme_pkg::in_t
//  out     | output    | out_valid_o / out_stall_i| mme_pkg::out_t
//  cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
//  A load word is written to its store when accepted, without leaving the idle
//  state. A compute word issues one store read pair per inner step on the two
//  RAM read ports, then the read, multiply and accumulate stages drain before
//  each product element. A dimension mismatch gives its error word instead.
//  Reset clears control and sets all four dimension registers to 1; store
//  contents are undefined until written. A stalled output holds the sequencer
//  before its next element; input words, loads too, are taken only while idle.
// ----------------------------------------------------------------------------
module matrix_multiply_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  mme_pkg::in_t                      in_word_i,
  output logic                              in_stall_o,
  output logic                              out_valid_o,
  output mme_pkg::out_t                     out_word_o,
  input  logic                              out_stall_i,
  input  logic                              cfg_we_i,
  input  logic [mme_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mme_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic [mme_pkg::CFG_DATA_W-1:0] left_rows_q, left_cols_q, right_rows_q, right_cols_q;
  logic [mme_pkg::CNT_W-1:0]      n_rows, n_inner, n_inner_r, n_cols;
  logic                           left_we, right_we, out_free, acc_done;
  logic [mme_pkg::ADDR_W-1:0]     waddr, left_raddr, right_raddr;
  logic [mme_pkg::ELEM_W-1:0]     wdata, left_rdata, right_rdata;
  logic signed [mme_pkg::RES_W-1:0] acc_value;
  mme_pkg::tag_t                  tag;
  mme_pkg::emit_t                 emit;
  logic                           out_valid_q;
  mme_pkg::out_t                  out_q;

  // Dimension registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_rows_q  <= mme_pkg::CFG_DATA_W'(1);
      left_cols_q  <= mme_pkg::CFG_DATA_W'(1);
      right_rows_q <= mme_pkg::CFG_DATA_W'(1);
      right_cols_q <= mme_pkg::CFG_DATA_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mme_pkg::CFG_LEFT_ROWS:  left_rows_q  <= cfg_data_i;
        mme_pkg::CFG_LEFT_COLS:  left_cols_q  <= cfg_data_i;
        mme_pkg::CFG_RIGHT_ROWS: right_rows_q <= cfg_data_i;
        mme_pkg::CFG_RIGHT_COLS: right_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign n_rows    = mme_pkg::eff_dim(left_rows_q);
  assign n_inner   = mme_pkg::eff_dim(left_cols_q);
  assign n_inner_r = mme_pkg::eff_dim(right_rows_q);
  assign n_cols    = mme_pkg::eff_dim(right_cols_q);

  // Sequencer
  mme_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_word_i     (in_word_i),
    .in_stall_o    (in_stall_o),
    .n_rows_i      (n_rows),
    .n_inner_i     (n_inner),
    .n_inner_r_i   (n_inner_r),
    .n_cols_i      (n_cols),
    .out_free_i    (out_free),
    .acc_done_i    (acc_done),
    .left_we_o     (left_we),
    .right_we_o    (right_we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .left_raddr_o  (left_raddr),
    .right_raddr_o (right_raddr),
    .tag_o         (tag),
    .emit_o        (emit)
  );

  // Element stores
  mme_ram #(
    .WIDTH (mme_pkg::ELEM_W),
    .DEPTH (mme_pkg::DEPTH)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (left_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (left_raddr),
    .rdata_o (left_rdata)
  );

  mme_ram #(
    .WIDTH (mme_pkg::ELEM_W),
    .DEPTH (mme_pkg::DEPTH)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (right_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (right_raddr),
    .rdata_o (right_rdata)
  );

  // Multiply-accumulate
  mme_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag),
    .left_i  (left_rdata),
    .right_i (right_rdata),
    .emit_i  (emit.load),
    .done_o  (acc_done),
    .value_o (acc_value)
  );

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_q.out_row   <= emit.row;
      out_q.out_col   <= emit.col;
      out_q.out_value <= emit.err ? '0 : acc_value;
      out_q.dim_error <= emit.err;
      out_q.last      <= emit.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

>>> tb/matrix_multiply_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_engine_tb
// Loads Q8.8 left and right matrices, issues compute words under a range of
// dimension settings, and checks every emitted product word, in order, against
// an in-bench matrix product with saturation to 32 bits.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_tb;
  import mme_pkg::*;

  localparam int          TARGET_WORDS = 470;
  localparam int          SETTLE       = 8;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
  localparam logic [15:0] Q_MAX        = 16'h7fff;
  localparam logic [15:0] Q_MIN        = 16'h8000;
  localparam longint      SAT_HI       = 64'sd2147483647;
  localparam longint      SAT_LO       = -64'sd2147483648;

  // Product predictor and queue of expected result words
  class matmul_checker;
    logic signed [ELEM_W-1:0] lhs [DEPTH];
    logic signed [ELEM_W-1:0] rhs [DEPTH];
    logic [CFG_DATA_W-1:0]    dim [4];
    out_t                     product_q [$];
    int                       fails;

    function new();
      foreach (dim[i]) dim[i] = CFG_DATA_W'(1);
      fails = 0;
    endfunction

    // zero acts as one, anything above MAX_DIM as MAX_DIM
    static function int clamp_dim(logic [CFG_DATA_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
    endfunction

    function int eff(logic [CFG_IDX_W-1:0] idx);
      return clamp_dim(dim[idx]);
    endfunction

    function void set_dim(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      dim[idx] = v;
    endfunction

    function int pending();
      return product_q.size();
    endfunction

    function void predict_product();
      int     n_rows, n_inner, n_cols, r, c, k;
      longint acc;
      out_t   word;
      n_rows  = eff(CFG_LEFT_ROWS);
      n_inner = eff(CFG_LEFT_COLS);
      n_cols  = eff(CFG_RIGHT_COLS);
      word    = '0;
      if (n_inner != eff(CFG_RIGHT_ROWS)) begin
        word.dim_error = 1'b1;
        word.last      = 1'b1;
        product_q.push_back(word);
        return;
      end
      for (r = 0; r < n_rows; r++) begin
        for (c = 0; c < n_cols; c++) begin
          acc = 0;
          for (k = 0; k < n_inner; k++) begin
            acc += longint'(lhs[r*MAX_DIM+k]) * longint'(rhs[k*MAX_DIM+c]);
          end
          if (acc > SAT_HI) begin
            acc = SAT_HI;
          end else if (acc < SAT_LO) begin
            acc = SAT_LO;
          end
          word.out_row   = DIM_W'(r);
          word.out_col   = DIM_W'(c);
          word.out_value = RES_W'(acc);
          word.last      = (r == n_rows - 1) && (c == n_cols - 1);
          product_q.push_back(word);
        end
      end
    endfunction

    // accepted input word: update the stores or queue the product
    function void note_word(in_t w);
      case (w.func)
        FUNC_LOAD_LEFT:  lhs[{w.elem_row, w.elem_col}] = w.elem_value;
        FUNC_LOAD_RIGHT: rhs[{w.elem_row, w.elem_col}] = w.elem_value;
        FUNC_COMPUTE:    predict_product();
        default: ;
      endcase
    endfunction

    // accepted result word against the oldest expectation
    function void check_word(out_t got);
      out_t want;
      if (product_q.size() == 0) begin
        $error("result word with none expected: row %0d col %0d value %0d",
               got.out_row, got.out_col, got.out_value);
        fails++;
        return;
      end
      want = product_q.pop_front();
      if (got.out_row !== want.out_row) begin
        $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
        fails++;
      end
      if (got.out_col !== want.out_col) begin
        $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
        fails++;
      end
      if (got.out_value !== want.out_value) begin
        $error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
        fails++;
      end
      if (got.dim_error !== want.dim_error) begin
        $error("dim_error: expected %0d, got %0d", want.dim_error, got.dim_error);
        fails++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        fails++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  in_t                   in_word_i;
  logic                  in_stall_o;
  logic                  out_valid_o;
  out_t                  out_word_o;
  logic                  out_stall_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  matmul_checker chk = new();
  bit            left_set [DEPTH];
  bit            right_set [DEPTH];
  int            words_sent;
  bit            tx_calm;
  bit            rx_calm;
  int unsigned   cycle_cnt = 0;

  matrix_multiply_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      chk.check_word(out_word_o);
    end
  end

  // Idle length: mostly none or short, a few long
  function automatic int idle_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Receiver stalls
  initial begin
    int n;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      n = idle_len(rx_calm);
      out_stall_i = (n != 0);
      repeat ((n == 0) ? 1 : n) @(negedge clk_i);
    end
  end

  function automatic logic [ELEM_W-1:0] rand_q88();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return Q_MAX;
    if (r < 20) return Q_MIN;
    if (r < 25) return '0;
    return ELEM_W'($urandom_range(0, 16'hffff));
  endfunction

  // Dimension register value: mostly small, some large, some out of range
  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return CFG_DATA_W'($urandom_range(MAX_DIM + 1, 15));
    if (r < 70) return CFG_DATA_W'($urandom_range(1, 3));
    return CFG_DATA_W'($urandom_range(4, MAX_DIM));
  endfunction

  // Present one word, hold it until taken, then maybe idle
  task automatic put_word(input in_t word);
    int                     gap;
    logic [$bits(in_t)-1:0] noise;
    in_valid_i = 1'b1;
    in_word_i  = word;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    chk.note_word(word);
    @(negedge clk_i);
    gap = idle_len(tx_calm);
    if (gap != 0) begin
      noise      = $bits(in_t)'($urandom);
      in_valid_i = 1'b0;
      in_word_i  = noise;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Sender pause until every expected word is back and the engine settles
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (chk.pending() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] v);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = v;
    @(posedge clk_i);
    chk.set_dim(idx, v);
    @(negedge clk_i);
  endtask

  task automatic set_shape(input logic [CFG_DATA_W-1:0] lr, lc, rr, rc);
    wait_drained();
    write_reg(CFG_LEFT_ROWS, lr);
    write_reg(CFG_LEFT_COLS, lc);
    write_reg(CFG_RIGHT_ROWS, rr);
    write_reg(CFG_RIGHT_COLS, rc);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_elem(input logic [1:0] fn, input int r, input int c,
                           input logic [ELEM_W-1:0] v);
    in_t word;
    word.func       = fn;
    word.elem_row   = DIM_W'(r);
    word.elem_col   = DIM_W'(c);
    word.elem_value = v;
    put_word(word);
    if (fn == FUNC_LOAD_LEFT) begin
      left_set[r*MAX_DIM+c] = 1'b1;
    end else begin
      right_set[r*MAX_DIM+c] = 1'b1;
    end
    words_sent++;
  endtask

  task automatic put_unused();
    in_t word;
    word.func       = FUNC_UNUSED;
    word.elem_row   = DIM_W'($urandom_range(0, MAX_DIM - 1));
    word.elem_col   = DIM_W'($urandom_range(0, MAX_DIM - 1));
    word.elem_value = rand_q88();
    put_word(word);
  endtask

  // Compute word; first fill any store entry it would read but never got
  task automatic run_compute();
    int  nr, ni, nc, r, c, k;
    in_t word;
    nr = chk.eff(CFG_LEFT_ROWS);
    ni = chk.eff(CFG_LEFT_COLS);
    nc = chk.eff(CFG_RIGHT_COLS);
    if (ni == chk.eff(CFG_RIGHT_ROWS)) begin
      for (r = 0; r < nr; r++) begin
        for (k = 0; k < ni; k++) begin
          if (!left_set[r*MAX_DIM+k]) load_elem(FUNC_LOAD_LEFT, r, k, rand_q88());
        end
      end
      for (k = 0; k < ni; k++) begin
        for (c = 0; c < nc; c++) begin
          if (!right_set[k*MAX_DIM+c]) load_elem(FUNC_LOAD_RIGHT, k, c, rand_q88());
        end
      end
    end
    word.func       = FUNC_COMPUTE;
    word.elem_row   = DIM_W'($urandom_range(0, MAX_DIM - 1));
    word.elem_col   = DIM_W'($urandom_range(0, MAX_DIM - 1));
    word.elem_value = rand_q88();
    put_word(word);
    words_sent++;
  endtask

  // Load at a random place, mostly inside the active shape
  task automatic random_load();
    logic [1:0] fn;
    int         rows, cols;
    fn = $urandom_range(0, 1) ? FUNC_LOAD_RIGHT : FUNC_LOAD_LEFT;
    if (fn == FUNC_LOAD_LEFT) begin
      rows = chk.eff(CFG_LEFT_ROWS);
      cols = chk.eff(CFG_LEFT_COLS);
    end else begin
      rows = chk.eff(CFG_RIGHT_ROWS);
      cols = chk.eff(CFG_RIGHT_COLS);
    end
    if ($urandom_range(0, 99) < 25) begin
      rows = MAX_DIM;
      cols = MAX_DIM;
    end
    load_elem(fn, $urandom_range(0, rows - 1), $urandom_range(0, cols - 1), rand_q88());
  endtask

  // Stimulus
  initial begin
    int                    k, n, r;
    logic [CFG_DATA_W-1:0] lr, lc, rr, rc;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_word_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    words_sent = 0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // 1x1: extreme operands
    set_shape(4'd1, 4'd1, 4'd1, 4'd1);
    load_elem(FUNC_LOAD_LEFT, 0, 0, Q_MAX);
    load_elem(FUNC_LOAD_RIGHT, 0, 0, Q_MIN);
    run_compute();
    load_elem(FUNC_LOAD_LEFT, 0, 0, Q_MIN);
    run_compute();

    // 1x4 by 4x2: sums saturate high in column 0, low in column 1
    set_shape(4'd1, 4'd4, 4'd4, 4'd2);
    for (k = 0; k < 4; k++) begin
      load_elem(FUNC_LOAD_LEFT, 0, k, Q_MIN);
      load_elem(FUNC_LOAD_RIGHT, k, 0, Q_MIN);
      load_elem(FUNC_LOAD_RIGHT, k, 1, Q_MAX);
    end
    put_unused();
    run_compute();

    // inner mismatch, out-of-range register values
    set_shape(4'd2, 4'd15, 4'd0, 4'd1);
    run_compute();

    // zero acts as one, above MAX_DIM as MAX_DIM
    set_shape(4'd0, 4'd0, 4'd1, 4'd9);
    run_compute();

    // Random phases
    while (words_sent < TARGET_WORDS) begin
      lr = pick_dim();
      lc = pick_dim();
      r  = $urandom_range(0, 99);
      if (r < 60) begin
        rr = lc;
      end else if (r < 80) begin
        // same effective inner size, different register value
        case (matmul_checker::clamp_dim(lc))
          1:       rr = CFG_DATA_W'($urandom_range(0, 1));
          MAX_DIM: rr = CFG_DATA_W'($urandom_range(MAX_DIM, 15));
          default: rr = lc;
        endcase
      end else begin
        rr = pick_dim();
      end
      rc = pick_dim();
      set_shape(lr, lc, rr, rc);
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      n = $urandom_range(8, 30);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          put_unused();
        end else if (r < 22) begin
          run_compute();
        end else begin
          random_load();
        end
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
      run_compute();
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (chk.fails == 0 && chk.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
